// ----- rtl/lb_clip_pkg.sv -----
// ----------------------------------------------------------------------------
// lb_clip_pkg
// Shared widths, types and helpers of the line clipper pipeline.
// ----------------------------------------------------------------------------
package lb_clip_pkg;

   localparam int COORD_BITS  = 12;
   localparam int FRAC_BITS   = 16;
   localparam int SCOORD_BITS = COORD_BITS + 1;
   localparam int U_BITS      = FRAC_BITS + 1;
   localparam int PROD_BITS   = COORD_BITS + FRAC_BITS + 1;
   localparam int NUM_EDGES   = 4;
   localparam int DIV_STAGES  = 4;
   localparam int DIV_STEPS   = (U_BITS + DIV_STAGES - 1) / DIV_STAGES;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic [COORD_BITS-1:0]         coord_type;
   typedef logic signed [SCOORD_BITS-1:0] scoord_type;
   typedef logic [U_BITS-1:0]             u_type;
   typedef logic [CSR_INDEX_BITS-1:0]     csr_index_type;

   localparam u_type U_ONE = u_type'(1) << FRAC_BITS;
   localparam u_type U_SAT = '1;

   localparam csr_index_type REG_CLIP_LEFT   = 2'd0;
   localparam csr_index_type REG_CLIP_RIGHT  = 2'd1;
   localparam csr_index_type REG_CLIP_BOTTOM = 2'd2;
   localparam csr_index_type REG_CLIP_TOP    = 2'd3;

   localparam coord_type RESET_CLIP_LEFT   = coord_type'(100);
   localparam coord_type RESET_CLIP_RIGHT  = coord_type'(300);
   localparam coord_type RESET_CLIP_BOTTOM = coord_type'(250);
   localparam coord_type RESET_CLIP_TOP    = coord_type'(350);

   typedef enum logic [1:0] {
      EDGE_SKIP,
      EDGE_REJECT,
      EDGE_EXIT,
      EDGE_ENTER
   } edge_kind_type;

   typedef struct packed {
      edge_kind_type kind;
      logic          sat;
   } edge_ctl_type;

   function automatic coord_type mag(scoord_type v);
      scoord_type n;
      n = -v;
      return v[SCOORD_BITS-1] ? n[COORD_BITS-1:0] : v[COORD_BITS-1:0];
   endfunction

   // decide what one edge test does before the quotient is known
   function automatic edge_ctl_type classify(scoord_type p, scoord_type q);
      edge_ctl_type c;
      logic         p_neg;
      logic         q_neg;
      p_neg = p[SCOORD_BITS-1];
      q_neg = q[SCOORD_BITS-1];
      if (p == '0) begin
         c.kind = q_neg ? EDGE_REJECT : EDGE_SKIP;
      end else if (q != '0 && (q_neg != p_neg)) begin
         c.kind = p_neg ? EDGE_SKIP : EDGE_REJECT;
      end else begin
         c.kind = p_neg ? EDGE_ENTER : EDGE_EXIT;
      end
      // quotient of two or more saturates
      c.sat = {1'b0, mag(q)} >= {mag(p), 1'b0};
      return c;
   endfunction

endpackage

// ----- rtl/liang_barsky_line_clipper.sv -----
// ----------------------------------------------------------------------------
// liang_barsky_line_clipper
// Pipelined parametric line clipper against a programmable window.
// ----------------------------------------------------------------------------
// Segments enter on the req_ channel and leave on the rsp_ channel, one
// result beat per segment, in order. A beat moves when valid is high and
// stall is low. The window edges are written through the csr_ channel,
// index 0..3 = left, right, bottom, top; csr_ready is always high and the
// window should only change while the pipeline is empty.
// Eight register stages: one prep stage for edge distances, four divider
// stages (up to five quotient bits per stage, one divider per edge), one
// edge-decision stage, one multiply stage and the rounding stage that is
// also the output register. The prep stage captures the req beat, and
// rsp_valid rises as the result enters the output register.
// Throughput is one segment per cycle unless the output stalls. When
// rsp_stall holds a waiting result, every stage freezes together and
// req_stall rises in the same cycle, so nothing is dropped or repeated.
// Reset clears all valid bits and loads the default window 100..300 in x
// and 250..350 in y.
// ----------------------------------------------------------------------------
module liang_barsky_line_clipper (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  lb_clip_pkg::coord_type        req_start_x,
   input  lb_clip_pkg::coord_type        req_start_y,
   input  lb_clip_pkg::coord_type        req_end_x,
   input  lb_clip_pkg::coord_type        req_end_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_visible,
   output lb_clip_pkg::coord_type        rsp_clipped_start_x,
   output lb_clip_pkg::coord_type        rsp_clipped_start_y,
   output lb_clip_pkg::coord_type        rsp_clipped_end_x,
   output lb_clip_pkg::coord_type        rsp_clipped_end_y,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  lb_clip_pkg::csr_index_type    csr_index,
   input  lb_clip_pkg::coord_type        csr_data
);

   localparam int NE = lb_clip_pkg::NUM_EDGES;
   localparam int DS = lb_clip_pkg::DIV_STAGES;

   typedef struct packed {
      lb_clip_pkg::coord_type                     sx;
      lb_clip_pkg::coord_type                     sy;
      lb_clip_pkg::scoord_type                    dx;
      lb_clip_pkg::scoord_type                    dy;
      lb_clip_pkg::edge_ctl_type [NE-1:0]         ctl;
   } side_type;

   logic adv;

   lb_clip_pkg::coord_type clip_left_ff, clip_right_ff, clip_bottom_ff, clip_top_ff;

   // prep stage
   lb_clip_pkg::scoord_type p_in [NE];
   lb_clip_pkg::scoord_type q_in [NE];
   side_type               side_in;
   lb_clip_pkg::coord_type magq_ff [NE];
   lb_clip_pkg::coord_type magp_ff [NE];
   side_type               side_ff [DS+1];
   logic                   vld_ff  [DS+1];
   lb_clip_pkg::u_type     quo     [NE];

   // decision stage
   logic                    keep_in;
   lb_clip_pkg::u_type      ue_in, ux_in;
   logic                    sel_valid_ff, sel_keep_ff;
   lb_clip_pkg::u_type      sel_ue_ff, sel_ux_ff;
   lb_clip_pkg::coord_type  sel_sx_ff, sel_sy_ff;
   lb_clip_pkg::scoord_type sel_dx_ff, sel_dy_ff;

   logic mul_valid_ff, mul_keep_ff;
   logic rsp_valid_ff, rsp_visible_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= lb_clip_pkg::RESET_CLIP_LEFT;
         clip_right_ff  <= lb_clip_pkg::RESET_CLIP_RIGHT;
         clip_bottom_ff <= lb_clip_pkg::RESET_CLIP_BOTTOM;
         clip_top_ff    <= lb_clip_pkg::RESET_CLIP_TOP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lb_clip_pkg::REG_CLIP_LEFT:   clip_left_ff   <= csr_data;
            lb_clip_pkg::REG_CLIP_RIGHT:  clip_right_ff  <= csr_data;
            lb_clip_pkg::REG_CLIP_BOTTOM: clip_bottom_ff <= csr_data;
            lb_clip_pkg::REG_CLIP_TOP:    clip_top_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // edge distances, order left, right, bottom, top
   always_comb begin
      lb_clip_pkg::scoord_type sx, sy, ex, ey, dx, dy;
      sx = $signed({1'b0, req_start_x});
      sy = $signed({1'b0, req_start_y});
      ex = $signed({1'b0, req_end_x});
      ey = $signed({1'b0, req_end_y});
      dx = ex - sx;
      dy = ey - sy;
      p_in[0] = -dx;
      q_in[0] = sx - $signed({1'b0, clip_left_ff});
      p_in[1] = dx;
      q_in[1] = $signed({1'b0, clip_right_ff}) - sx;
      p_in[2] = -dy;
      q_in[2] = sy - $signed({1'b0, clip_bottom_ff});
      p_in[3] = dy;
      q_in[3] = $signed({1'b0, clip_top_ff}) - sy;
      side_in.sx = req_start_x;
      side_in.sy = req_start_y;
      side_in.dx = dx;
      side_in.dy = dy;
      for (int i = 0; i < NE; i++) begin
         side_in.ctl[i] = lb_clip_pkg::classify(p_in[i], q_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 0; i < NE; i++) begin
            magq_ff[i] <= lb_clip_pkg::mag(q_in[i]);
            magp_ff[i] <= lb_clip_pkg::mag(p_in[i]);
         end
         for (int s = 1; s <= DS; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DS; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s <= DS; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   genvar e;
   generate
      for (e = 0; e < NE; e++) begin : g_div
         lb_clip_div u_div (
            .clock    (clock),
            .enable   (adv),
            .dividend (magq_ff[e]),
            .divisor  (magp_ff[e]),
            .quotient (quo[e])
         );
      end
   endgenerate

   // the edge tests in order left, right, bottom, top, each narrowing the entry/exit window
   always_comb begin
      lb_clip_pkg::u_type u;
      keep_in = 1'b1;
      ue_in   = '0;
      ux_in   = lb_clip_pkg::U_ONE;
      for (int i = 0; i < NE; i++) begin
         u = side_ff[DS].ctl[i].sat ? lb_clip_pkg::U_SAT : quo[i];
         if (keep_in) begin
            case (side_ff[DS].ctl[i].kind)
               lb_clip_pkg::EDGE_REJECT: keep_in = 1'b0;
               lb_clip_pkg::EDGE_EXIT: begin
                  if (u < ue_in) keep_in = 1'b0;
                  else if (u < ux_in) ux_in = u;
               end
               lb_clip_pkg::EDGE_ENTER: begin
                  if (u > ux_in) keep_in = 1'b0;
                  else if (u > ue_in) ue_in = u;
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sel_keep_ff <= keep_in;
         sel_ue_ff   <= ue_in;
         sel_ux_ff   <= ux_in;
         sel_sx_ff   <= side_ff[DS].sx;
         sel_sy_ff   <= side_ff[DS].sy;
         sel_dx_ff   <= side_ff[DS].dx;
         sel_dy_ff   <= side_ff[DS].dy;
         mul_keep_ff <= sel_keep_ff;
         rsp_visible_ff <= mul_keep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_valid_ff <= 1'b0;
         mul_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         sel_valid_ff <= vld_ff[DS];
         mul_valid_ff <= sel_valid_ff;
         rsp_valid_ff <= mul_valid_ff;
      end
   end

   lb_clip_interp u_start_x (
      .clock(clock), .enable(adv), .start(sel_sx_ff), .delta(sel_dx_ff),
      .u(sel_ue_ff), .keep(sel_keep_ff), .coord(rsp_clipped_start_x)
   );
   lb_clip_interp u_start_y (
      .clock(clock), .enable(adv), .start(sel_sy_ff), .delta(sel_dy_ff),
      .u(sel_ue_ff), .keep(sel_keep_ff), .coord(rsp_clipped_start_y)
   );
   lb_clip_interp u_end_x (
      .clock(clock), .enable(adv), .start(sel_sx_ff), .delta(sel_dx_ff),
      .u(sel_ux_ff), .keep(sel_keep_ff), .coord(rsp_clipped_end_x)
   );
   lb_clip_interp u_end_y (
      .clock(clock), .enable(adv), .start(sel_sy_ff), .delta(sel_dy_ff),
      .u(sel_ux_ff), .keep(sel_keep_ff), .coord(rsp_clipped_end_y)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

   // a rejected beat carries all-zero coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_visible |-> rsp_clipped_start_x == '0 &&
      rsp_clipped_start_y == '0 && rsp_clipped_end_x == '0 && rsp_clipped_end_y == '0)
      else $error("rejected segment with nonzero coordinates");

   // the last inner stage always lands in the output register when it moves
   a_mul_to_rsp: assert property (@(posedge clock) disable iff (reset)
      adv && mul_valid_ff |=> rsp_valid)
      else $error("result lost between multiply and output stage");

   // an empty output register never holds off the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

endmodule

// ----- rtl/lb_clip_div.sv -----
// ----------------------------------------------------------------------------
// lb_clip_div
// Pipelined restoring divider, |q|*2^F / |p| over a fixed number of stages.
// ----------------------------------------------------------------------------
module lb_clip_div (
   input  logic                    clock,
   input  logic                    enable,
   input  lb_clip_pkg::coord_type  dividend,
   input  lb_clip_pkg::coord_type  divisor,
   output lb_clip_pkg::u_type      quotient
);

   lb_clip_pkg::coord_type rem_src [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::coord_type dvs_src [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::u_type     quo_src [lb_clip_pkg::DIV_STAGES];
   logic                   lsb_src [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::coord_type rem_in  [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::u_type     quo_in  [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::coord_type rem_ff  [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::coord_type dvs_ff  [lb_clip_pkg::DIV_STAGES];
   lb_clip_pkg::u_type     quo_ff  [lb_clip_pkg::DIV_STAGES];

   genvar s;
   generate
      for (s = 0; s < lb_clip_pkg::DIV_STAGES; s++) begin : g_stage
         if (s == 0) begin : g_first
            // first step brings in the dividend lsb, the rest shift in zeros
            assign rem_src[s] = dividend >> 1;
            assign dvs_src[s] = divisor;
            assign quo_src[s] = '0;
            assign lsb_src[s] = dividend[0];
         end else begin : g_rest
            assign rem_src[s] = rem_ff[s-1];
            assign dvs_src[s] = dvs_ff[s-1];
            assign quo_src[s] = quo_ff[s-1];
            assign lsb_src[s] = 1'b0;
         end

         always_comb begin
            lb_clip_pkg::coord_type   r;
            lb_clip_pkg::u_type       qv;
            logic [lb_clip_pkg::COORD_BITS:0] t;
            int                       k;
            r  = rem_src[s];
            qv = quo_src[s];
            t  = '0;
            for (int j = 0; j < lb_clip_pkg::DIV_STEPS; j++) begin
               k = s * lb_clip_pkg::DIV_STEPS + j;
               if (k < lb_clip_pkg::U_BITS) begin
                  t = {r, (k == 0) ? lsb_src[s] : 1'b0};
                  if (t >= {1'b0, dvs_src[s]}) begin
                     t  = t - {1'b0, dvs_src[s]};
                     qv = {qv[lb_clip_pkg::U_BITS-2:0], 1'b1};
                  end else begin
                     qv = {qv[lb_clip_pkg::U_BITS-2:0], 1'b0};
                  end
                  r = t[lb_clip_pkg::COORD_BITS-1:0];
               end
            end
            rem_in[s] = r;
            quo_in[s] = qv;
         end

         always_ff @(posedge clock) begin
            if (enable) begin
               rem_ff[s] <= rem_in[s];
               dvs_ff[s] <= dvs_src[s];
               quo_ff[s] <= quo_in[s];
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[lb_clip_pkg::DIV_STAGES-1];

endmodule

// ----- rtl/lb_clip_interp.sv -----
// ----------------------------------------------------------------------------
// lb_clip_interp
// One clipped coordinate: start + u*d, rounded to nearest, over two stages.
// ----------------------------------------------------------------------------
module lb_clip_interp (
   input  logic                    clock,
   input  logic                    enable,
   input  lb_clip_pkg::coord_type  start,
   input  lb_clip_pkg::scoord_type delta,
   input  lb_clip_pkg::u_type      u,
   input  logic                    keep,
   output lb_clip_pkg::coord_type  coord
);

   localparam logic [lb_clip_pkg::PROD_BITS-1:0] HALF =
      lb_clip_pkg::PROD_BITS'(1) << (lb_clip_pkg::FRAC_BITS - 1);

   logic [lb_clip_pkg::PROD_BITS-1:0] base_ff;
   logic [lb_clip_pkg::PROD_BITS-1:0] prod_ff;
   logic [lb_clip_pkg::PROD_BITS-1:0] prod_in;
   logic [lb_clip_pkg::PROD_BITS-1:0] sum;
   logic                              neg_ff;
   logic                              keep_ff;
   lb_clip_pkg::coord_type            coord_ff;
   lb_clip_pkg::coord_type            coord_in;

   assign prod_in = lb_clip_pkg::PROD_BITS'(u) *
                    lb_clip_pkg::PROD_BITS'(lb_clip_pkg::mag(delta));

   always_ff @(posedge clock) begin
      if (enable) begin
         base_ff  <= lb_clip_pkg::PROD_BITS'({start, {lb_clip_pkg::FRAC_BITS{1'b0}}});
         prod_ff  <= prod_in;
         neg_ff   <= delta[lb_clip_pkg::SCOORD_BITS-1];
         keep_ff  <= keep;
         coord_ff <= coord_in;
      end
   end

   always_comb begin
      sum      = (neg_ff ? base_ff - prod_ff : base_ff + prod_ff) + HALF;
      coord_in = keep_ff ? sum[lb_clip_pkg::FRAC_BITS +: lb_clip_pkg::COORD_BITS] : '0;
   end

   assign coord = coord_ff;

endmodule
